// ===== src/itoar_pkg.sv =====
// Shared constants, codes and the digit glyph function for the radix text converter.
package itoar_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int BASE_W              = 6;
    localparam int LEN_W               = 7;
    localparam int CFG_DATA_W          = 7;
    localparam int CHAR_W              = 8;
    localparam int DIGIT_W             = 6;
    localparam int DIV_BITS_PER_CYCLE  = 4;

    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 36;
    localparam int LEN_MIN     = 2;
    localparam int BASE_RESET  = 10;
    localparam int LEN_RESET   = 10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_NUMBER_BASE   = 1'b0,
        REG_BUFFER_LENGTH = 1'b1
    } cfg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CONFIG = 2'd1,
        STATUS_NO_FIT     = 2'd2
    } status_t;

    // Map a digit value to its lower-case ASCII glyph; out-of-range maps to '0'.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] glyph;
        if (digit < DIGIT_W'(10)) begin
            glyph = CHAR_ZERO + CHAR_W'(digit);
        end else if (digit < DIGIT_W'(RADIX_MAX)) begin
            glyph = CHAR_LOW_A + CHAR_W'(digit) - CHAR_W'(10);
        end else begin
            glyph = CHAR_ZERO;
        end
        return glyph;
    endfunction

endpackage

// ===== src/signed_integer_to_ascii_radix_core.sv =====
// Top level of the signed integer to ASCII text converter in a configurable radix.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-----------------------------
//  input     | in        | start, busy (taken: start&!busy)| value
//  result    | out       | strobe (one cycle, no stall)   | character, last, status
//  config    | in        | cfg_wr_en                      | cfg_index, cfg_data
//
// Flow: each digit comes from one pass of the shared divider (4 quotient bits per
// cycle), then the fit check runs, then the sign and the digits leave. A bad radix
// or length answers in the cycle after the word is taken, with busy staying low.
// Reset clears the sequencer, counters and output strobe and loads both config
// registers with 10. The digit store needs no clearing: every entry is written
// before it is read. Once a word's text starts, results leave one per cycle and are never held off.
module signed_integer_to_ascii_radix_core
    import itoar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                          strobe,
    output logic [CHAR_W-1:0]             character,
    output logic                          last,
    output logic [1:0]                    status
);

    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CMP_W  = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [BASE_W-1:0]   number_base_reg;
    logic [LEN_W-1:0]    buffer_length_reg;
    logic [CNT_W-1:0]    digit_count_reg;
    logic [CNT_W-1:0]    digit_count_next;
    logic                negative_flag_reg;
    logic                negative_flag_next;
    logic                strobe_reg;
    logic                strobe_next;
    logic [CHAR_W-1:0]   character_reg;
    logic [CHAR_W-1:0]   character_next;
    logic                last_reg;
    logic                last_next;
    status_t             status_reg;
    status_t             status_next;

    // Digit store, least significant digit at entry zero
    logic [DIGIT_W-1:0]  digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;

    logic                     div_load;
    logic [VALUE_WIDTH-1:0]   div_operand;
    logic                     div_done;
    logic [VALUE_WIDTH-1:0]   div_quotient;
    logic [DIGIT_W-1:0]       div_remainder;

    logic [VALUE_WIDTH-1:0]   value_bits;
    logic [VALUE_WIDTH-1:0]   magnitude;
    logic                     config_bad;
    logic [CMP_W-1:0]         text_len;

    assign value_bits = value;
    // Take the magnitude unsigned so the most negative value converts too.
    assign magnitude  = value_bits[VALUE_WIDTH-1] ? (~value_bits + VALUE_WIDTH'(1))
                                                  : value_bits;
    assign config_bad = (number_base_reg < BASE_W'(RADIX_MIN))
                     || (number_base_reg > BASE_W'(RADIX_MAX))
                     || (buffer_length_reg < LEN_W'(LEN_MIN));
    assign text_len   = CMP_W'(digit_count_reg) + CMP_W'(negative_flag_reg);

    itoar_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .dividend  (div_operand),
        .divisor   (number_base_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Configuration registers: write any time the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg   <= BASE_W'(BASE_RESET);
            buffer_length_reg <= LEN_W'(LEN_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NUMBER_BASE:   number_base_reg   <= cfg_data[BASE_W-1:0];
                REG_BUFFER_LENGTH: buffer_length_reg <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer: answer a bad configuration at once, else divide repeatedly, check fit, then drain sign and digits.
    always_comb
    begin
        state_next         = state_reg;
        digit_count_next   = digit_count_reg;
        negative_flag_next = negative_flag_reg;
        strobe_next        = 1'b0;
        character_next     = character_reg;
        last_next          = last_reg;
        status_next        = status_reg;
        div_load           = 1'b0;
        div_operand        = div_quotient;
        mem_we             = 1'b0;
        rd_addr            = ADDR_W'(digit_count_reg - CNT_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    digit_count_next = '0;
                    if (config_bad)
                    begin
                        negative_flag_next = 1'b0;
                        strobe_next        = 1'b1;
                        character_next     = CHAR_NONE;
                        last_next          = 1'b1;
                        status_next        = STATUS_BAD_CONFIG;
                    end
                    else
                    begin
                        negative_flag_next = value_bits[VALUE_WIDTH-1];
                        div_load           = 1'b1;
                        div_operand        = magnitude;
                        state_next         = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (digit_count_reg < CNT_W'(VALUE_WIDTH))
                    begin
                        mem_we           = 1'b1;
                        digit_count_next = digit_count_reg + CNT_W'(1);
                    end
                    // Relaunch on the quotient until it reaches zero.
                    if (div_quotient != '0)
                    begin
                        div_load = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (text_len >= CMP_W'(buffer_length_reg))
                begin
                    digit_count_next   = '0;
                    negative_flag_next = 1'b0;
                    strobe_next        = 1'b1;
                    character_next     = CHAR_NONE;
                    last_next          = 1'b1;
                    status_next        = STATUS_NO_FIT;
                    state_next         = ST_IDLE;
                end
                else if (negative_flag_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SIGN:
            begin
                strobe_next    = 1'b1;
                character_next = CHAR_MINUS;
                last_next      = 1'b0;
                status_next    = STATUS_OK;
                state_next     = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Read data holds the digit for this cycle; fetch the next lower one.
                rd_addr          = ADDR_W'(digit_count_reg - CNT_W'(2));
                strobe_next      = 1'b1;
                character_next   = digit_glyph(rd_data_reg);
                last_next        = (digit_count_reg == CNT_W'(1));
                status_next      = STATUS_OK;
                digit_count_next = digit_count_reg - CNT_W'(1);
                if (digit_count_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            digit_count_reg   <= '0;
            negative_flag_reg <= 1'b0;
            strobe_reg        <= 1'b0;
            character_reg     <= CHAR_NONE;
            last_reg          <= 1'b0;
            status_reg        <= STATUS_OK;
        end
        else
        begin
            state_reg         <= state_next;
            digit_count_reg   <= digit_count_next;
            negative_flag_reg <= negative_flag_next;
            strobe_reg        <= strobe_next;
            character_reg     <= character_next;
            last_reg          <= last_next;
            status_reg        <= status_next;
        end
    end

    // Digit store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[digit_count_reg[ADDR_W-1:0]] <= div_remainder;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

// ===== src/itoar_div.sv =====
// Iterative restoring divider: magnitude by a narrow radix, a few quotient bits per cycle.
module itoar_div
    import itoar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [BASE_W-1:0]      divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]     remainder
);

    localparam int STEP_BITS = DIV_BITS_PER_CYCLE;
    localparam int PAD_W     = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS     = PAD_W / STEP_BITS;
    localparam int STEP_CW   = $clog2(STEPS + 1);

    logic [PAD_W-1:0]   acc_reg;
    logic [PAD_W-1:0]   acc_next;
    logic [DIGIT_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] rem_next;
    logic [STEP_CW-1:0] step_reg;
    logic               run_reg;
    logic               done_reg;

    // One radix-2 restoring step per bit; the partial remainder stays below the divisor.
    always_comb
    begin
        logic [DIGIT_W:0] trial;
        logic             fits;
        rem_next = rem_reg;
        acc_next = acc_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial = {rem_next, acc_next[PAD_W-1]};
            fits  = (trial >= {1'b0, divisor});
            if (fits)
            begin
                rem_next = DIGIT_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[DIGIT_W-1:0];
            end
            acc_next = {acc_next[PAD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (load)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_CW'(STEPS);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - STEP_CW'(1);
            if (step_reg == STEP_CW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= PAD_W'(dividend);
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = acc_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

// ===== src/itoar_checker.sv =====
// Port-level checks for the radix text converter, bound to the top level.
module itoar_checker
    import itoar_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              strobe,
    input logic [CHAR_W-1:0] character,
    input logic              last,
    input logic [1:0]        status
);

    // An error word is always the only, and so the final, word of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != STATUS_OK) |-> last)
    else $error("error result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != STATUS_OK) |-> (character == CHAR_NONE))
    else $error("error result carries a character");

    // More words follow a non-final one, so the block must still be working.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
    else $error("non-final result while idle");

    // Accepting a convertible word produces no word in the same step.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy && !$past(busy) |-> !strobe)
    else $error("result on the cycle work began");

    // The sign always leads digits and never closes a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status == STATUS_OK) && (character == CHAR_MINUS) |-> !last)
    else $error("sign marked as final character");

endmodule

bind signed_integer_to_ascii_radix_core itoar_checker u_itoar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last),
    .status    (status)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the signed integer to ASCII radix text converter.
`timescale 1ns / 100ps

module testbench;
    import itoar_pkg::*;

    localparam int  CLK_HALF      = 10;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  MAX_REPORTED  = 10;
    localparam int  WORD_W        = 32;

    // Glyph row for digit values 0..35, first glyph in the top byte.
    localparam logic [8*36-1:0] GLYPH_ROW = "0123456789abcdefghijklmnopqrstuvwxyz";

    // One emitted character with its marker and status.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        status_t           status;
    } text_char_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         start     = 1'b0;
    logic signed [WORD_W-1:0]     value     = '0;
    logic                         cfg_wr_en = 1'b0;
    logic                         cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         busy;
    logic                         strobe;
    logic [CHAR_W-1:0]            character;
    logic                         last;
    logic [1:0]                   status;

    // Shadow copies of the radix and buffer length registers.
    logic [BASE_W-1:0]            radix_reg  = BASE_W'(BASE_RESET);
    logic [LEN_W-1:0]             length_reg = LEN_W'(LEN_RESET);

    text_char_t                   pending_text[$];
    text_char_t                   expected_char;
    int                           mismatches  = 0;
    int                           cycle_count = 0;
    int                           idle_pct    = 0;

    signed_integer_to_ascii_radix_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .status    (status)
    );

    always #CLK_HALF clk = ~clk;

    // Hard stop in case the block hangs or drops a word.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Work out the characters one word turns into under the current registers
    // and append them to the pending text.
    function automatic void predict_text(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0]  magnitude;
        logic               negative;
        logic [DIGIT_W-1:0] digits [WORD_W];
        int                 count;
        int                 k;
        if (radix_reg < RADIX_MIN || radix_reg > RADIX_MAX || length_reg < LEN_MIN)
        begin
            pending_text.push_back('{CHAR_NONE, 1'b1, STATUS_BAD_CONFIG});
            return;
        end
        negative  = word[WORD_W-1];
        // Negating the most negative value wraps back to itself, which is
        // exactly its unsigned magnitude.
        magnitude = negative ? -word : word;
        count     = 0;
        do
        begin
            digits[count] = DIGIT_W'(magnitude % radix_reg);
            count++;
            magnitude = magnitude / radix_reg;
        end
        while (magnitude != 0);
        // Sign plus digits must leave room for the terminator.
        if (count + int'(negative) >= int'(length_reg))
        begin
            pending_text.push_back('{CHAR_NONE, 1'b1, STATUS_NO_FIT});
            return;
        end
        if (negative)
            pending_text.push_back('{CHAR_MINUS, 1'b0, STATUS_OK});
        for (k = count - 1; k >= 0; k--)
            pending_text.push_back('{GLYPH_ROW[8*(35-int'(digits[k])) +: 8],
                                     k == 0, STATUS_OK});
    endfunction

    // Compare every strobed character with the oldest one still pending.
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("%0t: unexpected result char %h last %b status %0d",
                             $realtime, character, last, status);
            end
            else
            begin
                expected_char = pending_text.pop_front();
                if (character !== expected_char.character || last !== expected_char.last ||
                    status !== expected_char.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("%0t: expected char %h last %b status %0d, got %h %b %0d",
                                 $realtime, expected_char.character, expected_char.last,
                                 expected_char.status, character, last, status);
                end
            end
        end
    end

    // Offer one word and hold it until the block takes it, then idle the
    // input side at random. Without idling start stays high so the next word
    // follows at once.
    task automatic send_word(input logic [WORD_W-1:0] word);
        bit lowered;
        lowered = 1'b0;
        value <= word;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_text(word);
        while ($urandom_range(99) < idle_pct)
        begin
            if (!lowered)
                start <= 1'b0;
            lowered = 1'b1;
            @(posedge clk);
        end
    endtask

    // Drop start and wait until all pending text has come out and the block
    // has gone quiet.
    task automatic settle();
        start <= 1'b0;
        while (pending_text.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers while the block is idle and track them.
    task automatic set_registers(input logic [CFG_DATA_W-1:0] radix_data,
                                 input logic [CFG_DATA_W-1:0] length_data);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NUMBER_BASE;
        cfg_data  <= radix_data;
        @(posedge clk);
        radix_reg = radix_data[BASE_W-1:0];
        cfg_index <= REG_BUFFER_LENGTH;
        cfg_data  <= length_data;
        @(posedge clk);
        length_reg = length_data[LEN_W-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    // Random word: full range, small magnitudes, extremes or scaled values.
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] word;
        case ($urandom_range(4))
            0: word = $urandom;
            1: word = WORD_W'($urandom_range(100));
            2:
            begin
                case ($urandom_range(4))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    3: word = 32'h0000_0001;
                    default: word = '0;
                endcase
            end
            default: word = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(1) == 1 && word != 32'h8000_0000)
            word = -word;
        return word;
    endfunction

    // Mostly legal settings with lengths that usually fit, some that are too
    // short and a few illegal ones. Bit 6 of the radix data is ignored by the
    // block, so toggle it freely.
    task automatic random_registers();
        logic [CFG_DATA_W-1:0] radix_data;
        logic [CFG_DATA_W-1:0] length_data;
        if ($urandom_range(9) == 0)
            radix_data = ($urandom_range(1) == 1) ? CFG_DATA_W'($urandom_range(1))
                                                  : CFG_DATA_W'($urandom_range(37, 63));
        else
            radix_data = CFG_DATA_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        radix_data[CFG_DATA_W-1] = $urandom_range(1);
        case ($urandom_range(19))
            0:          length_data = CFG_DATA_W'($urandom_range(1));
            1, 2:       length_data = CFG_DATA_W'($urandom_range(65, 127));
            3, 4, 5, 6: length_data = CFG_DATA_W'($urandom_range(LEN_MIN, 19));
            default:    length_data = CFG_DATA_W'($urandom_range(20, 64));
        endcase
        set_registers(radix_data, length_data);
    endtask

    // Reset values: radix ten, room for nine characters.
    task automatic test_reset_registers();
        send_word(32'd0);
        send_word(32'd1);
        send_word(-32'sd1);
        send_word(32'd123456789);
        send_word(-32'sd12345678);
        send_word(32'd1000000000);
        send_word(-32'sd123456789);
    endtask

    // Widest and narrowest radix with a 64-character buffer; the most negative
    // value in binary gives the longest text.
    task automatic test_extreme_radix();
        set_registers(CFG_DATA_W'(RADIX_MAX), CFG_DATA_W'(64));
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'd35);
        set_registers(CFG_DATA_W'(RADIX_MIN), CFG_DATA_W'(64));
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'd0);
    endtask

    // Text one shorter than the buffer fits, text as long as the buffer does not.
    task automatic test_fit_boundary();
        set_registers(CFG_DATA_W'(16), CFG_DATA_W'(9));
        send_word(32'h7FFF_FFFF);
        send_word(-32'sh1000_0000);
        set_registers(CFG_DATA_W'(16), CFG_DATA_W'(10));
        send_word(-32'sh1000_0000);
        set_registers(CFG_DATA_W'(10), CFG_DATA_W'(LEN_MIN));
        send_word(32'd9);
        send_word(32'd10);
        send_word(-32'sd1);
    endtask

    // Radix below two or above 36 and buffers shorter than two.
    task automatic test_bad_settings();
        set_registers(CFG_DATA_W'(0), CFG_DATA_W'(10));
        send_word(32'd5);
        set_registers(CFG_DATA_W'(1), CFG_DATA_W'(10));
        send_word(32'd5);
        set_registers(CFG_DATA_W'(37), CFG_DATA_W'(10));
        send_word(32'd5);
        set_registers(7'h7F, CFG_DATA_W'(10));
        send_word(-32'sd5);
        set_registers(CFG_DATA_W'(10), CFG_DATA_W'(0));
        send_word(32'd5);
        set_registers(CFG_DATA_W'(10), CFG_DATA_W'(1));
        send_word(32'd5);
    endtask

    // Random words under a few random settings, at the given idle rate.
    task automatic test_random_words(input int sender_idle_pct);
        idle_pct = sender_idle_pct;
        repeat (4)
        begin
            random_registers();
            repeat (7) send_word(random_word());
        end
        idle_pct = 0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_extreme_radix();
        test_fit_boundary();
        test_bad_settings();

        // The receiver cannot stall, so its phases run with the sender alone.
        test_random_words(0);
        test_random_words(54);
        test_random_words(0);
        test_random_words(31);

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
